// File: sv/range_window_curb_detector_macros.svh
// assertion macros used by the checker file
`ifndef RANGE_WINDOW_CURB_DETECTOR_MACROS_SVH
`define RANGE_WINDOW_CURB_DETECTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RWCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rwcd assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define RWCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rwcd assertion failed");

`endif

// File: sv/rwcd_pkg.sv
// shared constants and types of the range window curb detector
package rwcd_pkg;

  localparam int NEIGHBORS = 3;
  localparam int COLUMNS   = 1800;
  localparam int WIN_LEN   = 2 * NEIGHBORS + 1;
  localparam int DIFF_CNT  = WIN_LEN - 1;

  localparam int RANGE_W = 16;
  localparam int RATIO_W = 10;
  localparam int COL_W   = 11;
  localparam int CNT_W   = $clog2(COLUMNS + 1);
  localparam int EXT_W   = (CNT_W > COL_W) ? CNT_W : COL_W;
  localparam int PROD_W  = RANGE_W + RATIO_W;

  localparam logic [PROD_W-1:0] PERMILLE = PROD_W'(1000);

  localparam logic [CNT_W-1:0] COLUMNS_C   = CNT_W'(COLUMNS);
  localparam logic [CNT_W-1:0] FIRST_JUDGE = CNT_W'(2 * NEIGHBORS);
  localparam logic [CNT_W-1:0] LAST_COL    = CNT_W'(COLUMNS - 1);
  localparam logic [EXT_W-1:0] NEIGH_EXT   = EXT_W'(NEIGHBORS);
  localparam logic [COL_W-1:0] END_CENTRE  = COL_W'(COLUMNS - 1 - NEIGHBORS);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_RANGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_PERMILLE = 2'd2;

  localparam logic [RANGE_W-1:0] RANGE_LIMIT_RST    = 16'd5120;
  localparam logic [RANGE_W-1:0] INVALID_RANGE_RST  = 16'd0;
  localparam logic [RATIO_W-1:0] RATIO_PERMILLE_RST = 10'd30;

  typedef logic [RANGE_W-1:0] sample_t;

  typedef struct packed {
    logic inv;
    logic eq;
    logic gt;
  } cell_flags_t;

  typedef struct packed {
    logic [RANGE_W-1:0] max_centre;
    logic [RANGE_W-1:0] invalid_range;
    logic [RATIO_W-1:0] ratio_permille;
  } cfg_t;

endpackage

// File: sv/rwcd_cell.sv
// one window cell: holds a sample, shifts from its neighbor, flags it
module rwcd_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  rwcd_pkg::sample_t     d_in,
  input  rwcd_pkg::sample_t     invalid_range,
  output rwcd_pkg::sample_t     sample,
  output rwcd_pkg::cell_flags_t flags
);

  rwcd_pkg::sample_t sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else if (shift_en) begin
      sample_r <= d_in;
    end
  end

  // d_in is the right neighbor's sample (the new input in the last cell), so compare against it
  always_comb begin
    flags.inv = (sample_r == invalid_range);
    flags.eq  = (sample_r == d_in);
    flags.gt  = (sample_r > d_in);
  end

  assign sample = sample_r;

endmodule

// File: sv/rwcd_judge.sv
// window judgment: range limit, invalid marker, monotonic run, ratio test
module rwcd_judge (
  input  rwcd_pkg::sample_t     win   [rwcd_pkg::WIN_LEN],
  input  rwcd_pkg::cell_flags_t flags [rwcd_pkg::WIN_LEN],
  input  rwcd_pkg::cfg_t        cfg,
  output logic                  obstacle
);

  logic                          any_inv;
  logic                          any_eq;
  logic                          all_gt;
  logic                          none_gt;
  logic                          in_limit;
  logic [rwcd_pkg::RANGE_W-1:0]  span;
  logic [rwcd_pkg::PROD_W-1:0]   span_scaled;
  logic [rwcd_pkg::PROD_W-1:0]   need;
  rwcd_pkg::sample_t             centre;
  rwcd_pkg::sample_t             first;
  rwcd_pkg::sample_t             last;

  always_comb begin
    any_inv = 1'b0;
    any_eq  = 1'b0;
    all_gt  = 1'b1;
    none_gt = 1'b1;
    for (int i = 0; i < rwcd_pkg::WIN_LEN; i++) begin
      any_inv = any_inv | flags[i].inv;
    end
    for (int i = 0; i < rwcd_pkg::DIFF_CNT; i++) begin
      any_eq  = any_eq | flags[i].eq;
      all_gt  = all_gt & flags[i].gt;
      none_gt = none_gt & ~flags[i].gt;
    end
  end

  assign centre   = win[rwcd_pkg::NEIGHBORS];
  assign first    = win[0];
  assign last     = win[rwcd_pkg::WIN_LEN-1];
  assign in_limit = (centre <= cfg.max_centre);
  assign span     = (first > last) ? (first - last) : (last - first);

  assign span_scaled = rwcd_pkg::PROD_W'(span) * rwcd_pkg::PERMILLE;
  assign need        = rwcd_pkg::PROD_W'(cfg.ratio_permille) * rwcd_pkg::PROD_W'(centre);

  assign obstacle = in_limit && !any_inv && !any_eq && (all_gt || none_gt) &&
                    (span_scaled >= need);

endmodule

// File: sv/range_window_curb_detector.sv
// top level of the range window curb detector
//
// in_*  : one range sample per request, column 0 first. in_tdata[15:0] is the
//         range (unsigned Q8.8 m), in_tuser[0] marks column 0 of a new row.
// out_* : one judgment per centre column NEIGHBORS .. COLUMNS-NEIGHBORS-1.
//         out_tdata[10:0] column, out_tuser[0] obstacle, out_tlast last
//         judged column of the row. Other input requests give no result.
// cfg_* : register writes (0 range limit, 1 invalid marker, 2 ratio per
//         mille), always ready. The user writes them only while no request
//         is in flight; the block itself does not enforce this.
// Throughput is one request per cycle when not stalled; the window cells shift
// once per accepted request. The request that completes a window loads the
// cells and column counter, then the output register takes the judgment from
// the cells. Reset clears the window, the column count and all valid flags,
// and loads the register defaults. A stalled out_tready holds the output
// register and drops in_tready, so nothing is lost while the receiver waits.
module range_window_curb_detector (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // range
  input  logic [0:0]                      in_tuser,   // row_start
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // column, zero pad
  output logic [0:0]                      out_tuser,  // obstacle
  output logic                            out_tlast,  // row_end
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rwcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data
);

  rwcd_pkg::cfg_t                cfg_r;
  rwcd_pkg::sample_t             win   [rwcd_pkg::WIN_LEN];
  rwcd_pkg::cell_flags_t         flags [rwcd_pkg::WIN_LEN];

  logic                          advance;
  logic                          in_acc;
  logic [rwcd_pkg::CNT_W-1:0]    cnt_r;
  logic [rwcd_pkg::CNT_W-1:0]    cnt_nxt;
  logic [rwcd_pkg::CNT_W-1:0]    col_now;
  logic [rwcd_pkg::EXT_W-1:0]    centre_ext;
  logic                          has_result;
  logic                          s1_vld_r;
  logic [rwcd_pkg::COL_W-1:0]    s1_col_r;
  logic                          s1_end_r;
  logic                          obstacle;
  logic                          out_vld_r;
  logic [rwcd_pkg::COL_W-1:0]    out_col_r;
  logic                          out_obs_r;
  logic                          out_end_r;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_centre     <= rwcd_pkg::RANGE_LIMIT_RST;
      cfg_r.invalid_range  <= rwcd_pkg::INVALID_RANGE_RST;
      cfg_r.ratio_permille <= rwcd_pkg::RATIO_PERMILLE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rwcd_pkg::REG_RANGE_LIMIT:    cfg_r.max_centre     <= cfg_data;
        rwcd_pkg::REG_INVALID_RANGE:  cfg_r.invalid_range  <= cfg_data;
        rwcd_pkg::REG_RATIO_PERMILLE: cfg_r.ratio_permille <= cfg_data[rwcd_pkg::RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = advance;
  assign in_acc    = in_tvalid && in_tready;

  // column counter
  assign col_now    = in_tuser[0] ? '0 : cnt_r;
  assign cnt_nxt    = (col_now < rwcd_pkg::COLUMNS_C) ? col_now + 1'b1 : col_now;
  assign has_result = (col_now < rwcd_pkg::COLUMNS_C) && (col_now >= rwcd_pkg::FIRST_JUDGE);
  assign centre_ext = rwcd_pkg::EXT_W'(col_now) - rwcd_pkg::NEIGH_EXT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= cnt_nxt;
    end
  end

  // window chain, cell WIN_LEN-1 takes the new sample
  for (genvar g = 0; g < rwcd_pkg::WIN_LEN; g++) begin : g_cell
    if (g == rwcd_pkg::WIN_LEN - 1) begin : g_tail
      rwcd_cell u_cell (
        .clk           (clk),
        .rst_n         (rst_n),
        .shift_en      (in_acc),
        .d_in          (in_tdata),
        .invalid_range (cfg_r.invalid_range),
        .sample        (win[g]),
        .flags         (flags[g])
      );
    end else begin : g_body
      rwcd_cell u_cell (
        .clk           (clk),
        .rst_n         (rst_n),
        .shift_en      (in_acc),
        .d_in          (win[g+1]),
        .invalid_range (cfg_r.invalid_range),
        .sample        (win[g]),
        .flags         (flags[g])
      );
    end
  end

  // stage one: request metadata alongside the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r <= in_acc && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r <= centre_ext[rwcd_pkg::COL_W-1:0];
      s1_end_r <= (col_now == rwcd_pkg::LAST_COL);
    end
  end

  rwcd_judge u_judge (
    .win      (win),
    .flags    (flags),
    .cfg      (cfg_r),
    .obstacle (obstacle)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_col_r <= s1_col_r;
      out_obs_r <= obstacle;
      out_end_r <= s1_end_r;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = {{(16 - rwcd_pkg::COL_W){1'b0}}, out_col_r};
  assign out_tuser[0] = out_obs_r;
  assign out_tlast    = out_end_r;

endmodule

// File: sv/rwcd_checker.sv
// port-level checker for the range window curb detector, bound to the top
`include "range_window_curb_detector_macros.svh"

module rwcd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [15:0]                     out_tdata,
  input logic [0:0]                      out_tuser,
  input logic                            out_tlast
);

  // stalled result holds its payload
  `RWCD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // an empty output register never blocks the input
  `RWCD_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready)

  // row end only on the last judged centre
  `RWCD_ASSERT_NOW(a_row_end_col, out_tvalid && out_tlast,
    out_tdata[rwcd_pkg::COL_W-1:0] == rwcd_pkg::END_CENTRE)

  // stalled output always drops input ready
  `RWCD_ASSERT_NOW(a_stall_blocks, out_tvalid && !out_tready, !in_tready)

endmodule

bind range_window_curb_detector rwcd_checker u_rwcd_checker (.*);

// File: tb/sv/tb_range_window_curb_detector.sv
// self-checking testbench of the range window curb detector with its own judgment predictor
module tb_range_window_curb_detector;

  typedef struct packed {
    logic [rwcd_pkg::RANGE_W-1:0] sample_range;
    logic                         row_start;
  } sample_req_t;

  typedef struct packed {
    logic [rwcd_pkg::COL_W-1:0] column;
    logic                       obstacle;
    logic                       row_end;
  } judgment_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [15:0]                    in_tdata;   // range
  logic [0:0]                     in_tuser;   // row_start
  logic                           out_tvalid;
  logic                           out_tready;
  logic [15:0]                    out_tdata;  // column, zero pad
  logic [0:0]                     out_tuser;  // obstacle
  logic                           out_tlast;  // row_end
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rwcd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                    cfg_data;

  range_window_curb_detector uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sample_req_t pending_samples[$];
  judgment_t   judgments_due[$];
  int          samples_queued;
  int          samples_taken;
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        in_fire;

  // predictor state
  rwcd_pkg::cfg_t             cur_cfg;
  rwcd_pkg::sample_t          win[rwcd_pkg::WIN_LEN];
  logic [rwcd_pkg::CNT_W-1:0] col_count;

  // range generator state
  logic [15:0] gen_val;
  int          gen_left;
  int          gen_mode;
  int          gen_step;
  bit          gen_up;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic judge_centre();
    logic [31:0] centre;
    logic [31:0] first;
    logic [31:0] last;
    logic [63:0] span;
    int          dir;
    int          s;
    centre = win[rwcd_pkg::NEIGHBORS];
    first  = win[0];
    last   = win[rwcd_pkg::WIN_LEN-1];
    if (centre > cur_cfg.max_centre) return 1'b0;
    for (int i = 0; i < rwcd_pkg::WIN_LEN; i++)
      if (win[i] == cur_cfg.invalid_range) return 1'b0;
    dir = 0;
    for (int i = 0; i < rwcd_pkg::WIN_LEN - 1; i++) begin
      if (win[i] == win[i+1]) return 1'b0;
      s = (win[i] > win[i+1]) ? 1 : -1;
      if (dir != 0 && s != dir) return 1'b0;
      dir = s;
    end
    span = (first > last) ? 64'(first - last) : 64'(last - first);
    return (span * 64'd1000) >= (64'(cur_cfg.ratio_permille) * 64'(centre));
  endfunction

  task automatic take_sample(sample_req_t s);
    logic [rwcd_pkg::CNT_W-1:0] col;
    judgment_t                  j;
    if (s.row_start) col_count = '0;
    col = col_count;
    if (col_count < rwcd_pkg::COLUMNS_C) col_count++;
    for (int i = 0; i < rwcd_pkg::WIN_LEN - 1; i++) win[i] = win[i+1];
    win[rwcd_pkg::WIN_LEN-1] = s.sample_range;
    if (col < rwcd_pkg::COLUMNS_C && col >= rwcd_pkg::FIRST_JUDGE) begin
      j.column   = rwcd_pkg::COL_W'(col) - rwcd_pkg::COL_W'(rwcd_pkg::NEIGHBORS);
      j.obstacle = judge_centre();
      j.row_end  = (col == rwcd_pkg::LAST_COL);
      judgments_due = {judgments_due, j};
    end
  endtask

  // ramps of random slope, noise and near-flat stretches, with some invalid markers
  function automatic logic [15:0] next_range();
    if (gen_left == 0) begin
      gen_left = $urandom_range(3, 14);
      gen_mode = $urandom_range(0, 9);
      gen_up   = 1'($urandom_range(0, 1));
      gen_step = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : $urandom_range(1, 3000);
      if ($urandom_range(0, 1) != 0) gen_val = 16'($urandom_range(0, 8000));
      else gen_val = 16'($urandom);
    end
    gen_left--;
    if ($urandom_range(0, 39) == 0) return cur_cfg.invalid_range;
    if (gen_mode < 6) gen_val = gen_up ? gen_val + 16'(gen_step) : gen_val - 16'(gen_step);
    else if (gen_mode < 8) gen_val = 16'($urandom);
    else if ($urandom_range(0, 1) != 0) gen_val = gen_val + 16'($urandom_range(0, 1));
    return gen_val;
  endfunction

  task automatic push_sample(logic [15:0] r, logic s);
    sample_req_t q;
    q.sample_range = r;
    q.row_start    = s;
    pending_samples = {pending_samples, q};
    samples_queued++;
  endtask

  task automatic push_rows(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      for (int i = 0; i < len; i++)
        push_sample(next_range(), (i == 0) && ($urandom_range(0, 9) != 0));
      sent += len;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (samples_taken != samples_queued || judgments_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [rwcd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rwcd_pkg::REG_RANGE_LIMIT:    cur_cfg.max_centre = val;
      rwcd_pkg::REG_INVALID_RANGE:  cur_cfg.invalid_range = val;
      rwcd_pkg::REG_RATIO_PERMILLE: cur_cfg.ratio_permille = val[rwcd_pkg::RATIO_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_cfg(logic [15:0] limit, logic [15:0] inv, logic [15:0] ratio);
    write_reg(rwcd_pkg::REG_RANGE_LIMIT, limit);
    write_reg(rwcd_pkg::REG_INVALID_RANGE, inv);
    write_reg(rwcd_pkg::REG_RATIO_PERMILLE, ratio);
  endtask

  // driver
  always @(negedge clk) begin
    sample_req_t head;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        head = pending_samples.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= head.sample_range;
        in_tuser  <= head.row_start;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    sample_req_t got;
    judgment_t   want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        got.sample_range = in_tdata;
        got.row_start    = in_tuser[0];
        take_sample(got);
        samples_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (judgments_due.size() == 0) begin
          $display("%0t unexpected result: expected none, got column %0d obstacle %0b row_end %0b",
                   $time, out_tdata, out_tuser[0], out_tlast);
          mismatches++;
        end else begin
          want = judgments_due.pop_front();
          if (out_tdata != 16'(want.column)) begin
            $display("%0t column mismatch: expected %0d, got %0d", $time, want.column, out_tdata);
            mismatches++;
          end
          if (out_tuser[0] != want.obstacle) begin
            $display("%0t obstacle mismatch at column %0d: expected %0b, got %0b",
                     $time, want.column, want.obstacle, out_tuser[0]);
            mismatches++;
          end
          if (out_tlast != want.row_end) begin
            $display("%0t row_end mismatch at column %0d: expected %0b, got %0b",
                     $time, want.column, want.row_end, out_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    samples_queued = 0;
    samples_taken  = 0;
    mismatches     = 0;
    send_idle_pct  = 16;
    recv_stall_pct = 70;
    gen_val        = '0;
    gen_left       = 0;
    gen_mode       = 0;
    gen_step       = 1;
    gen_up         = 1'b0;
    cur_cfg.max_centre     = rwcd_pkg::RANGE_LIMIT_RST;
    cur_cfg.invalid_range  = rwcd_pkg::INVALID_RANGE_RST;
    cur_cfg.ratio_permille = rwcd_pkg::RATIO_PERMILLE_RST;
    for (int i = 0; i < rwcd_pkg::WIN_LEN; i++) win[i] = '0;
    col_count = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first row without row_start, rising ramp
    for (int i = 1; i <= 7; i++) push_sample(16'(i * 100), 1'b0);
    // short row, extremes, no judgment
    push_sample(16'hFFFF, 1'b1);
    push_sample(16'h0000, 1'b0);
    push_sample(16'h0001, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    // falling ramp crossing the range limit
    for (int i = 0; i < 9; i++) push_sample(16'(6000 - i * 200), i == 0);
    // ramp too shallow for the ratio, then an equal pair
    for (int i = 0; i < 7; i++) push_sample(16'(3000 + i), i == 0);
    push_sample(16'd3006, 1'b0);
    push_rows(190);
    wait_idle();

    write_cfg(16'hFFFF, 16'hFFFF, 16'd0);
    // zero centre and a ramp that ends at zero
    push_sample(16'd10, 1'b1);
    push_sample(16'd8, 1'b0);
    push_sample(16'd5, 1'b0);
    push_sample(16'd0, 1'b0);
    push_sample(16'd3, 1'b0);
    push_sample(16'd6, 1'b0);
    push_sample(16'd9, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    for (int i = 0; i < 7; i++) push_sample(16'(60 - i * 10), i == 0);
    push_rows(190);
    wait_idle();

    send_idle_pct  = 70;
    recv_stall_pct = 16;
    write_cfg(16'd40000, 16'd0, 16'd1023);
    push_rows(190);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_cfg(16'd0, 16'($urandom), 16'($urandom_range(0, 1023)));
    push_rows(190);
    wait_idle();

    if (mismatches == 0) begin
      $display("tb_range_window_curb_detector OK");
    end else begin
      $display("tb_range_window_curb_detector NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_range_window_curb_detector NOT OK");
    $finish;
  end

endmodule

// File: range_window_curb_detector.f
+incdir+sv
sv/rwcd_pkg.sv
sv/rwcd_cell.sv
sv/rwcd_judge.sv
sv/range_window_curb_detector.sv
sv/rwcd_checker.sv
tb/sv/tb_range_window_curb_detector.sv
